>>> rtl/qjts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted JSON token splitter package
// Shared constants, character codes and payload types of the splitter.
// ----------------------------------------------------------------------------
package qjts_pkg;

    localparam int MAX_LINE   = 4096;
    localparam int DEPTH_BITS = 8;
    localparam int POS_W      = $clog2(MAX_LINE);
    localparam int LPOS_W     = POS_W + 1;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [1:0] {
        KIND_TEXT   = 2'd0,
        KIND_DQUOTE = 2'd1,
        KIND_SQUOTE = 2'd2,
        KIND_JSON   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]  token_start;
        logic [LPOS_W-1:0] token_length;
        t_kind             token_kind;
        logic              overflow;
    } t_out_item;

endpackage

>>> rtl/qjts_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Splitter input stage
// Registers one accepted character request until the scanner consumes it.
// ----------------------------------------------------------------------------
module qjts_in_stage
    import qjts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

>>> rtl/qjts_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Splitter scanner
// Holds the line state and decides, per character, whether a token ends.
// ----------------------------------------------------------------------------
module qjts_scan
    import qjts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output logic      o_emit,
    output t_out_item o_token
);

    typedef logic signed [DEPTH_BITS-1:0] t_depth;

    typedef struct packed {
        logic [7:0]        prev_char;
        logic [7:0]        quote_char;
        t_depth            brace_depth;
        t_depth            bracket_depth;
        logic              in_quoted;
        logic              in_json;
        logic              in_json_string;
        logic              json_string_seen;
        logic [LPOS_W-1:0] line_pos;
        logic [POS_W-1:0]  first_text_pos;
        logic [POS_W-1:0]  last_text_pos;
        logic              has_text;
        logic              overflow_seen;
    } t_scan_state;

    localparam t_depth DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam t_depth DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    t_scan_state r_state;
    t_scan_state n_state;

    logic [7:0]       c;
    logic             escaped;
    logic             pos_sat;
    logic             blank;
    logic             emit;
    logic [POS_W-1:0] pos;

    always_comb begin
        c       = i_item.line_end ? CH_SPACE : i_item.char_code;
        escaped = (r_state.prev_char == CH_BSLASH);
        pos_sat = (r_state.line_pos >= LPOS_W'(MAX_LINE));
        blank   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        emit    = (c == CH_SPACE) && !r_state.in_quoted && !r_state.in_json &&
                  (r_state.has_text || r_state.prev_char == r_state.quote_char);
        pos     = pos_sat ? POS_W'(MAX_LINE - 1) : r_state.line_pos[POS_W-1:0];
    end

    always_comb begin
        o_emit = emit;
        o_token.token_start  = r_state.has_text ? r_state.first_text_pos : '0;
        o_token.token_length = r_state.has_text ?
            ({1'b0, r_state.last_text_pos} - {1'b0, r_state.first_text_pos} + LPOS_W'(1)) :
            '0;
        priority if (r_state.quote_char == CH_DQUOTE) begin
            o_token.token_kind = KIND_DQUOTE;
        end else if (r_state.quote_char == CH_SQUOTE) begin
            o_token.token_kind = KIND_SQUOTE;
        end else if (r_state.json_string_seen) begin
            o_token.token_kind = KIND_JSON;
        end else begin
            o_token.token_kind = KIND_TEXT;
        end
        o_token.overflow = r_state.overflow_seen;
    end

    always_comb begin
        n_state = r_state;
        priority if (emit) begin
            n_state.has_text       = 1'b0;
            n_state.first_text_pos = '0;
            n_state.last_text_pos  = '0;
            n_state.prev_char      = '0;
            n_state.quote_char     = '0;
            if (i_item.line_end) begin
                n_state = '0;
            end else if (pos_sat) begin
                n_state.overflow_seen = 1'b1;
            end else begin
                n_state.line_pos = r_state.line_pos + LPOS_W'(1);
            end
        end else if (i_item.line_end) begin
            n_state = '0;
        end else begin
            if (pos_sat) begin
                n_state.overflow_seen = 1'b1;
            end else begin
                n_state.line_pos = r_state.line_pos + LPOS_W'(1);
            end

            priority if (r_state.in_json_string) begin
                if (c == CH_DQUOTE && !escaped) begin
                    n_state.in_json_string = 1'b0;
                end
            end else if (r_state.in_json) begin
                priority if (c == CH_DQUOTE) begin
                    n_state.json_string_seen = 1'b1;
                    n_state.in_json_string   = 1'b1;
                end else if (c == CH_LBRACE) begin
                    if (r_state.brace_depth != DEPTH_MAX) begin
                        n_state.brace_depth = r_state.brace_depth + t_depth'(1);
                    end else begin
                        n_state.overflow_seen = 1'b1;
                    end
                end else if (c == CH_RBRACE) begin
                    if (r_state.brace_depth != DEPTH_MIN) begin
                        n_state.brace_depth = r_state.brace_depth - t_depth'(1);
                    end else begin
                        n_state.overflow_seen = 1'b1;
                    end
                end else if (c == CH_LBRACK) begin
                    if (r_state.bracket_depth != DEPTH_MAX) begin
                        n_state.bracket_depth = r_state.bracket_depth + t_depth'(1);
                    end else begin
                        n_state.overflow_seen = 1'b1;
                    end
                end else if (c == CH_RBRACK) begin
                    if (r_state.bracket_depth != DEPTH_MIN) begin
                        n_state.bracket_depth = r_state.bracket_depth - t_depth'(1);
                    end else begin
                        n_state.overflow_seen = 1'b1;
                    end
                end else begin
                    n_state.in_json = r_state.in_json;
                end
                if (n_state.brace_depth == '0 && n_state.bracket_depth == '0) begin
                    n_state.in_json = 1'b0;
                end
            end else if (r_state.in_quoted) begin
                if (c == r_state.quote_char && !escaped) begin
                    n_state.in_quoted = 1'b0;
                end
            end else if ((c == CH_DQUOTE || c == CH_SQUOTE) && !escaped) begin
                n_state.quote_char = c;
                n_state.in_quoted  = 1'b1;
            end else if ((c == CH_LBRACE || c == CH_LBRACK) && !escaped) begin
                if (c == CH_LBRACE) begin
                    if (r_state.brace_depth != DEPTH_MAX) begin
                        n_state.brace_depth = r_state.brace_depth + t_depth'(1);
                    end else begin
                        n_state.overflow_seen = 1'b1;
                    end
                end else begin
                    if (r_state.bracket_depth != DEPTH_MAX) begin
                        n_state.bracket_depth = r_state.bracket_depth + t_depth'(1);
                    end else begin
                        n_state.overflow_seen = 1'b1;
                    end
                end
                n_state.in_json = 1'b1;
            end else begin
                n_state.in_quoted = r_state.in_quoted;
            end

            if (!blank) begin
                if (!r_state.has_text) begin
                    n_state.first_text_pos = pos;
                end
                n_state.last_text_pos = pos;
                n_state.has_text      = 1'b1;
            end
            n_state.prev_char = (c == CH_BSLASH && escaped) ? 8'h00 : c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/qjts_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Splitter output stage
// Holds one token request until the downstream side takes it.
// ----------------------------------------------------------------------------
module qjts_out_stage
    import qjts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_token,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_token
);

    logic      r_valid;
    t_out_item r_token;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_token = r_token;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_token <= i_token;
        end
    end

endmodule

>>> rtl/quoted_json_token_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted JSON token splitter
// Splits a character stream into space separated tokens, honoring quotes,
// backslash escapes and nested JSON spans, and reports offset, length and kind.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_ready   i_in_item  (char, line end)
//   out      output     o_out_valid / i_out_ready o_out_item (token)
//
// One character request is taken every cycle while the output is not stalled;
// the character ending a token is registered in the input stage, the token in the
// output stage as the scanner steps; its line state updates once per character.
// Reset is synchronous and active low and clears both stages and the state.
// A stalled output holds the scanner, which in turn holds the input stage.
// ----------------------------------------------------------------------------
module quoted_json_token_splitter
    import qjts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      in_valid;
    t_in_item  in_item;
    logic      out_free;
    logic      step;
    logic      emit;
    t_out_item token;

    assign step = in_valid && out_free;

    qjts_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .i_take  (step),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    qjts_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (in_item),
        .o_emit  (emit),
        .o_token (token)
    );

    qjts_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && emit),
        .i_token (token),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_token (o_out_item)
    );

endmodule

>>> tb/quoted_json_token_splitter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quoted JSON token splitter testbench
// Feeds character requests through the input handshake and checks every token
// against a cycle-free model of the splitter kept inside the bench. Directed
// lines cover separators, quotes, escapes, JSON spans and depth saturation;
// random lines then mix well-formed spans with noise, while both sides of the
// block stall in random bursts during the first random run.
// ----------------------------------------------------------------------------
module quoted_json_token_splitter_test;
    import qjts_pkg::*;

    localparam int DEPTH_HI   = (1 << (DEPTH_BITS - 1)) - 1;
    localparam int DEPTH_LO   = -(1 << (DEPTH_BITS - 1));
    localparam int DRAIN_WAIT = 16;
    localparam int PRINT_CAP  = 50;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    int  mismatches = 0;
    int  items_fed  = 0;
    int  hold_len   = 0;
    bit  calm       = 1'b0;

    logic [7:0]        last_char;
    logic [7:0]        open_quote;
    int                brace_lvl;
    int                brack_lvl;
    bit                in_quote_span;
    bit                in_json_span;
    bit                in_json_str;
    bit                json_str_seen;
    bit                tok_has_text;
    bit                line_ovf;
    logic [LPOS_W-1:0] line_count;
    logic [POS_W-1:0]  tok_first;
    logic [POS_W-1:0]  tok_last;
    t_out_item         token_q[$];
    t_out_item         want_tok;

    quoted_json_token_splitter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    function void clear_line();
        last_char     = 8'h00;
        open_quote    = 8'h00;
        brace_lvl     = 0;
        brack_lvl     = 0;
        in_quote_span = 1'b0;
        in_json_span  = 1'b0;
        in_json_str   = 1'b0;
        json_str_seen = 1'b0;
        tok_has_text  = 1'b0;
        line_ovf      = 1'b0;
        line_count    = '0;
        tok_first     = '0;
        tok_last      = '0;
    endfunction

    initial clear_line();

    function automatic int nudge_depth(input int lvl, input int dir);
        if (dir > 0 && lvl < DEPTH_HI) begin
            return lvl + 1;
        end
        if (dir < 0 && lvl > DEPTH_LO) begin
            return lvl - 1;
        end
        line_ovf = 1'b1;
        return lvl;
    endfunction

    // Advances the line state by one accepted request and queues the token
    // that the request closes, if any.
    function automatic void split_char(input t_in_item req);
        logic [7:0]       c;
        bit               esc;
        logic [POS_W-1:0] at;
        t_out_item        tok;
        c   = req.line_end ? CH_SPACE : req.char_code;
        esc = (last_char == CH_BSLASH);
        if (c == CH_SPACE && !in_quote_span && !in_json_span
                && (tok_has_text || last_char == open_quote)) begin
            tok.token_start  = tok_has_text ? tok_first : '0;
            tok.token_length = tok_has_text ? ({1'b0, tok_last} - {1'b0, tok_first} + 1'b1)
                                            : '0;
            if (open_quote == CH_DQUOTE) begin
                tok.token_kind = KIND_DQUOTE;
            end else if (open_quote == CH_SQUOTE) begin
                tok.token_kind = KIND_SQUOTE;
            end else if (json_str_seen) begin
                tok.token_kind = KIND_JSON;
            end else begin
                tok.token_kind = KIND_TEXT;
            end
            tok.overflow = line_ovf;
            token_q = {token_q, tok};
            tok_has_text = 1'b0;
            tok_first    = '0;
            tok_last     = '0;
            last_char    = 8'h00;
            open_quote   = 8'h00;
            if (req.line_end) begin
                clear_line();
            end else if (line_count >= MAX_LINE) begin
                line_ovf = 1'b1;
            end else begin
                line_count++;
            end
            return;
        end
        if (req.line_end) begin
            clear_line();
            return;
        end
        if (line_count >= MAX_LINE) begin
            line_ovf = 1'b1;
            at = POS_W'(MAX_LINE - 1);
        end else begin
            at = line_count[POS_W-1:0];
            line_count++;
        end
        if (in_json_str) begin
            if (c == CH_DQUOTE && !esc) begin
                in_json_str = 1'b0;
            end
        end else if (in_json_span) begin
            case (c)
                CH_DQUOTE: begin
                    json_str_seen = 1'b1;
                    in_json_str   = 1'b1;
                end
                CH_LBRACE: brace_lvl = nudge_depth(brace_lvl, 1);
                CH_RBRACE: brace_lvl = nudge_depth(brace_lvl, -1);
                CH_LBRACK: brack_lvl = nudge_depth(brack_lvl, 1);
                CH_RBRACK: brack_lvl = nudge_depth(brack_lvl, -1);
                default: ;
            endcase
            if (brace_lvl == 0 && brack_lvl == 0) begin
                in_json_span = 1'b0;
            end
        end else if (in_quote_span) begin
            if (c == open_quote && !esc) begin
                in_quote_span = 1'b0;
            end
        end else if ((c == CH_DQUOTE || c == CH_SQUOTE) && !esc) begin
            open_quote    = c;
            in_quote_span = 1'b1;
        end else if ((c == CH_LBRACE || c == CH_LBRACK) && !esc) begin
            if (c == CH_LBRACE) begin
                brace_lvl = nudge_depth(brace_lvl, 1);
            end else begin
                brack_lvl = nudge_depth(brack_lvl, 1);
            end
            in_json_span = 1'b1;
        end
        if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))) begin
            if (!tok_has_text) begin
                tok_first = at;
            end
            tok_last     = at;
            tok_has_text = 1'b1;
        end
        last_char = (c == CH_BSLASH && esc) ? 8'h00 : c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP) begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (token_q.size() == 0) begin
                report_mismatch("token with none pending", 1, 0);
            end else begin
                want_tok = token_q.pop_front();
                if (o_out_item.token_start !== want_tok.token_start) begin
                    report_mismatch("token_start", o_out_item.token_start,
                                    want_tok.token_start);
                end
                if (o_out_item.token_length !== want_tok.token_length) begin
                    report_mismatch("token_length", o_out_item.token_length,
                                    want_tok.token_length);
                end
                if (o_out_item.token_kind !== want_tok.token_kind) begin
                    report_mismatch("token_kind", int'(o_out_item.token_kind),
                                    int'(want_tok.token_kind));
                end
                if (o_out_item.overflow !== want_tok.overflow) begin
                    report_mismatch("overflow", o_out_item.overflow, want_tok.overflow);
                end
            end
        end
    end

    initial begin
        forever begin
            if (hold_len != 0) begin
                i_out_ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
                hold_len = 0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic feed_item(input logic [7:0] code, input logic le);
        t_in_item req;
        if (!calm && $urandom_range(0, 11) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        req.char_code = code;
        req.line_end  = le;
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        split_char(req);
        items_fed++;
    endtask

    task automatic feed_char(input logic [7:0] code);
        feed_item(code, 1'b0);
    endtask

    task automatic end_line();
        feed_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic feed_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            feed_char(s[k]);
        end
    endtask

    function automatic logic [7:0] random_letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    task automatic drain_tokens();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (token_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        while (token_q.size() != 0) begin
            want_tok = token_q.pop_front();
            report_mismatch("missing token at offset", -1, want_tok.token_start);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic test_separators();
        feed_text(" ab  c\t");
        feed_char(8'h00);
        feed_char(8'hFF);
        end_line();
        feed_text("x\t");
        end_line();
    endtask

    task automatic test_quotes_escapes();
        feed_text("\"a b\" 'c\\' d' \\\"e \\\\\"f g\" 'open");
        end_line();
    endtask

    task automatic test_json_spans();
        feed_text("{\"k\\\"\":[1 2]} {]x[} \\{ y");
        end_line();
        feed_text("[a {b");
        end_line();
    endtask

    task automatic test_depth_saturation();
        feed_char(CH_SPACE);
        repeat (DEPTH_HI + 3) feed_char(CH_LBRACE);
        repeat (DEPTH_HI + 3) feed_char(CH_RBRACK);
        repeat (DEPTH_HI + 1) feed_char(CH_LBRACK);
        repeat (DEPTH_HI) feed_char(CH_RBRACE);
        feed_text(" z ");
        end_line();
        feed_text("a ");
        end_line();
    endtask

    task automatic test_output_hold();
        calm = 1'b1;
        hold_len = 80;
        for (int k = 0; k < 40; k++) begin
            feed_char((k % 2 == 1) ? CH_SPACE : random_letter());
        end
        end_line();
        calm = 1'b0;
    endtask

    task automatic test_drain_pause();
        feed_text("x \"y z\" ");
        drain_tokens();
        feed_text("after ");
        end_line();
    endtask

    task automatic random_quoted(input logic [7:0] q);
        feed_char(q);
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 4))
                0, 1: feed_char(random_letter());
                2: feed_char(CH_SPACE);
                3: begin
                    feed_char(CH_BSLASH);
                    feed_char(q);
                end
                default: feed_char((q == CH_DQUOTE) ? CH_SQUOTE : CH_DQUOTE);
            endcase
        end
        feed_char(q);
    endtask

    task automatic random_json_string();
        feed_char(CH_DQUOTE);
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 4))
                0, 1: feed_char(random_letter());
                2: feed_char(CH_SPACE);
                3: feed_char(($urandom_range(0, 1) == 1) ? CH_LBRACE : CH_RBRACK);
                default: begin
                    feed_char(CH_BSLASH);
                    feed_char(CH_DQUOTE);
                end
            endcase
        end
        feed_char(CH_DQUOTE);
    endtask

    task automatic random_json();
        logic [7:0] closers[$];
        logic [7:0] c;
        c = ($urandom_range(0, 1) == 1) ? CH_LBRACE : CH_LBRACK;
        feed_char(c);
        closers = {closers, ((c == CH_LBRACE) ? CH_RBRACE : CH_RBRACK)};
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 5))
                0: begin
                    if (closers.size() < 4) begin
                        c = ($urandom_range(0, 1) == 1) ? CH_LBRACE : CH_LBRACK;
                        feed_char(c);
                        closers = {closers, ((c == CH_LBRACE) ? CH_RBRACE : CH_RBRACK)};
                    end
                end
                1: begin
                    if (closers.size() > 1) begin
                        feed_char(closers.pop_back());
                    end
                end
                2: random_json_string();
                3: feed_char(CH_SPACE);
                4: feed_char(($urandom_range(0, 1) == 1) ? 8'h3A : 8'h2C);
                default: feed_char(random_letter());
            endcase
        end
        while (closers.size() != 0) begin
            feed_char(closers.pop_back());
        end
    endtask

    // Mostly well-formed words and spans with random content; the rest is blank
    // runs, stray bytes, loose escapes and early line ends that leave spans open.
    task automatic test_random_lines(input int count);
        int base;
        base = items_fed;
        while (items_fed - base < count) begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3: repeat ($urandom_range(1, 6)) feed_char(random_letter());
                4: random_quoted(CH_DQUOTE);
                5: random_quoted(CH_SQUOTE);
                6, 7: random_json();
                8: begin
                    repeat ($urandom_range(1, 3)) begin
                        feed_char(($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13))
                                                                : CH_SPACE);
                    end
                end
                9: repeat ($urandom_range(1, 3)) feed_char(8'($urandom_range(0, 255)));
                10: begin
                    feed_char(CH_BSLASH);
                    case ($urandom_range(0, 5))
                        0: feed_char(CH_DQUOTE);
                        1: feed_char(CH_SQUOTE);
                        2: feed_char(CH_LBRACE);
                        3: feed_char(CH_LBRACK);
                        4: feed_char(CH_BSLASH);
                        default: feed_char(random_letter());
                    endcase
                end
                default: end_line();
            endcase
            if ($urandom_range(0, 3) != 0) begin
                feed_char(CH_SPACE);
            end
        end
        end_line();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_separators();
        test_quotes_escapes();
        test_json_spans();
        test_depth_saturation();
        test_output_hold();
        test_drain_pause();
        test_random_lines(950);
        calm = 1'b1;
        test_random_lines(250);
        drain_tokens();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
